### design/fprq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fprq_pkg;

	// Frame word that opens and closes every packet.
	localparam logic [31:0] FRAME_MAGIC = 32'h5850_5053;

	// Function codes of a request.
	localparam logic [1:0] FN_BEGIN = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	// Status codes of a response.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
	localparam logic [2:0] ST_LEN_BAD   = 3'd4;
	localparam logic [2:0] ST_TOO_BIG   = 3'd5;
	localparam logic [2:0] ST_NO_WRITE  = 3'd6;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic [11:0] payload_len;
		logic [31:0] flow;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  read_byte;
		logic [31:0] read_flow;
		logic [11:0] read_len;
		logic        last;
		logic [31:0] message_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR,
		S_RD,
		S_CHK,
		S_PAY,
		S_AFTB,
		S_CHKT,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		P_HDR,
		P_BYTE,
		P_TRL
	} phase_t;

endpackage
`default_nettype wire

### design/framed_packet_ring_queue_unit.sv
// Channel   Direction  Payload          Handshake
// req       in         fprq_pkg::req_t  req_valid / req_ready
// rsp       out        fprq_pkg::rsp_t  rsp_valid / rsp_ready
// cfg       in         13-bit limit     cfg_we, no wait
// One transaction is handled at a time. A begin write stores the 12-byte header, and
// also the 4-byte trailer with an empty payload; a payload byte write stores its byte,
// and the trailer too on the last byte. A read fetches the 12-byte header when it opens
// a packet, then one payload byte if any is left, then the 4-byte trailer for checking
// once no payload is left. A refused begin or write, an empty read and a clear skip the ring.
// Reset clears all pointers and counters at once; ring contents are not cleared.
// A response waiting on rsp_ready holds the unit before it returns to accept.
`timescale 1ns / 1ps
`default_nettype none
module framed_packet_ring_queue_unit #(
	parameter int RING_BYTES = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fprq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output fprq_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [12:0]    cfg_wdata
);

	localparam int AW = $clog2(RING_BYTES);
	typedef logic [AW-1:0] ptr_t;

	// Pointer advance modulo the ring size.
	function automatic ptr_t wadd(ptr_t p, logic [4:0] n);
		logic [AW:0] s;
		s = {1'b0, p} + (AW+1)'(n);
		if (s >= (AW+1)'(RING_BYTES)) begin
			s = s - (AW+1)'(RING_BYTES);
		end
		return s[AW-1:0];
	endfunction

	fprq_pkg::state_t state_q, state_d;
	fprq_pkg::phase_t phase_q;

	ptr_t        rp_q, cp_q, wwp_q, ra_q;
	ptr_t        read_left_q;
	logic [11:0] write_left_q;
	logic        write_open_q, read_open_q;
	logic [31:0] open_flow_q, msg_q;
	logic [11:0] open_len_q;
	logic [12:0] max_read_q;
	logic [AW:0] used_q;

	logic [127:0] wbuf_q;
	logic [4:0]   wn_q, wcnt_q;
	logic         fin_q;
	logic [3:0]   rn_q, icnt_q, ccnt_q;
	logic         rv_s1;
	logic [95:0]  hdr_q;

	logic [2:0] res_status_q;
	logic [7:0] res_byte_q;
	logic       res_last_q, res_rd_q;
	logic       rsp_valid_q;
	fprq_pkg::rsp_t rsp_q;

	logic       ram_we, ram_re;
	ptr_t       ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	fprq_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Space and header checks.
	logic [AW:0]  free_w, used_w;
	logic         full_w, wr_done, rd_done, slot_free;
	logic [31:0]  h_magic, h_total, h_tag;
	logic [2:0]   h_status;

	always_comb begin
		free_w = (rp_q > cp_q) ? ({1'b0, rp_q} - {1'b0, cp_q})
			: ({1'b0, rp_q} + (AW+1)'(RING_BYTES) - {1'b0, cp_q});
		used_w = (cp_q > rp_q) ? ({1'b0, cp_q} - {1'b0, rp_q})
			: ({1'b0, cp_q} + (AW+1)'(RING_BYTES) - {1'b0, rp_q});
		full_w = 33'(free_w) <= (33'(req.payload_len) + 33'd16);
		h_magic = hdr_q[31:0];
		h_total = hdr_q[63:32];
		h_tag   = hdr_q[95:64];
		if (h_magic != fprq_pkg::FRAME_MAGIC) begin
			h_status = fprq_pkg::ST_BAD_MAGIC;
		end else if (h_total > 32'(used_q) || h_total < 32'd16) begin
			h_status = fprq_pkg::ST_LEN_BAD;
		end else if ((h_total - 32'd12) > 32'(max_read_q)) begin
			h_status = fprq_pkg::ST_TOO_BIG;
		end else begin
			h_status = fprq_pkg::ST_OK;
		end
		wr_done   = (wcnt_q == wn_q - 5'd1);
		rd_done   = rv_s1 && (ccnt_q == rn_q - 4'd1);
		slot_free = !rsp_valid_q || rsp_ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fprq_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req.func)
						fprq_pkg::FN_BEGIN: state_d = full_w ? fprq_pkg::S_RESP : fprq_pkg::S_WR;
						fprq_pkg::FN_WRITE: state_d = write_open_q ? fprq_pkg::S_WR : fprq_pkg::S_RESP;
						fprq_pkg::FN_READ: begin
							if (read_open_q) begin
								state_d = fprq_pkg::S_PAY;
							end else if (rp_q == cp_q) begin
								state_d = fprq_pkg::S_RESP;
							end else begin
								state_d = fprq_pkg::S_RD;
							end
						end
						default: state_d = fprq_pkg::S_RESP;
					endcase
				end
			end
			fprq_pkg::S_WR: if (wr_done) state_d = fprq_pkg::S_RESP;
			fprq_pkg::S_RD: begin
				if (rd_done) begin
					case (phase_q)
						fprq_pkg::P_HDR:  state_d = fprq_pkg::S_CHK;
						fprq_pkg::P_BYTE: state_d = fprq_pkg::S_AFTB;
						default:          state_d = fprq_pkg::S_CHKT;
					endcase
				end
			end
			fprq_pkg::S_CHK: begin
				state_d = (h_status != fprq_pkg::ST_OK) ? fprq_pkg::S_RESP : fprq_pkg::S_PAY;
			end
			fprq_pkg::S_PAY:  state_d = fprq_pkg::S_RD;
			fprq_pkg::S_AFTB: begin
				state_d = (read_left_q == ptr_t'(1)) ? fprq_pkg::S_RD : fprq_pkg::S_RESP;
			end
			fprq_pkg::S_CHKT: state_d = fprq_pkg::S_RESP;
			fprq_pkg::S_RESP: if (slot_free) state_d = fprq_pkg::S_IDLE;
			default: state_d = fprq_pkg::S_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		req_ready = (state_q == fprq_pkg::S_IDLE);
		ram_we    = (state_q == fprq_pkg::S_WR);
		ram_waddr = wwp_q;
		ram_wdata = wbuf_q[7:0];
		ram_re    = (state_q == fprq_pkg::S_RD) && (icnt_q != rn_q);
		ram_raddr = ra_q;
		rsp_valid = rsp_valid_q;
		rsp       = rsp_q;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fprq_pkg::S_IDLE;
			phase_q      <= fprq_pkg::P_HDR;
			rp_q         <= '0;
			cp_q         <= '0;
			wwp_q        <= '0;
			ra_q         <= '0;
			read_left_q  <= '0;
			write_left_q <= '0;
			write_open_q <= 1'b0;
			read_open_q  <= 1'b0;
			open_flow_q  <= '0;
			open_len_q   <= '0;
			msg_q        <= '0;
			max_read_q   <= 13'd4096;
			used_q       <= '0;
			wbuf_q       <= '0;
			wn_q         <= '0;
			wcnt_q       <= '0;
			fin_q        <= 1'b0;
			rn_q         <= '0;
			icnt_q       <= '0;
			ccnt_q       <= '0;
			rv_s1        <= 1'b0;
			hdr_q        <= '0;
			res_status_q <= fprq_pkg::ST_OK;
			res_byte_q   <= '0;
			res_last_q   <= 1'b0;
			res_rd_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= ram_re;
			if (cfg_we) begin
				max_read_q <= cfg_wdata;
			end
			// The response slot fills from the response state and empties on acceptance.
			if (state_q == fprq_pkg::S_RESP && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				fprq_pkg::S_IDLE: begin
					if (req_valid) begin
						res_byte_q   <= '0;
						res_last_q   <= 1'b0;
						res_rd_q     <= 1'b0;
						wcnt_q       <= '0;
						case (req.func)
							fprq_pkg::FN_BEGIN: begin
								write_open_q <= !full_w;
								write_left_q <= full_w ? 12'd0 : req.payload_len;
								res_status_q <= full_w ? fprq_pkg::ST_FULL : fprq_pkg::ST_OK;
								wwp_q  <= cp_q;
								wbuf_q <= {fprq_pkg::FRAME_MAGIC, req.flow,
									32'(req.payload_len) + 32'd16, fprq_pkg::FRAME_MAGIC};
								fin_q  <= (req.payload_len == 12'd0);
								wn_q   <= (req.payload_len == 12'd0) ? 5'd16 : 5'd12;
							end
							fprq_pkg::FN_WRITE: begin
								if (!write_open_q) begin
									res_status_q <= fprq_pkg::ST_NO_WRITE;
								end else begin
									res_status_q <= fprq_pkg::ST_OK;
									wbuf_q       <= {88'd0, fprq_pkg::FRAME_MAGIC, req.data_byte};
									fin_q        <= (write_left_q == 12'd1);
									wn_q         <= (write_left_q == 12'd1) ? 5'd5 : 5'd1;
									write_left_q <= write_left_q - 12'd1;
								end
							end
							fprq_pkg::FN_READ: begin
								if (!read_open_q) begin
									if (rp_q == cp_q) begin
										res_status_q <= fprq_pkg::ST_EMPTY;
									end else begin
										res_status_q <= fprq_pkg::ST_OK;
										if (msg_q != 32'd0) begin
											msg_q <= msg_q - 32'd1;
										end
										used_q  <= used_w;
										ra_q    <= rp_q;
										rn_q    <= 4'd12;
										icnt_q  <= '0;
										ccnt_q  <= '0;
										phase_q <= fprq_pkg::P_HDR;
									end
								end else begin
									res_status_q <= fprq_pkg::ST_OK;
								end
							end
							default: begin
								res_status_q <= fprq_pkg::ST_OK;
								rp_q         <= '0;
								cp_q         <= '0;
								wwp_q        <= '0;
								write_left_q <= '0;
								write_open_q <= 1'b0;
								read_left_q  <= '0;
								read_open_q  <= 1'b0;
								open_flow_q  <= '0;
								open_len_q   <= '0;
								msg_q        <= '0;
							end
						endcase
					end
				end
				// Stream bytes of the write buffer into the ring.
				fprq_pkg::S_WR: begin
					wbuf_q <= {8'd0, wbuf_q[127:8]};
					wcnt_q <= wcnt_q + 5'd1;
					wwp_q  <= wadd(wwp_q, 5'd1);
					if (wr_done && fin_q) begin
						cp_q         <= wadd(wwp_q, 5'd1);
						write_open_q <= 1'b0;
						msg_q        <= msg_q + 32'd1;
					end
				end
				// Fetch bytes; data arrives in the cycle after each address.
				fprq_pkg::S_RD: begin
					if (ram_re) begin
						ra_q   <= wadd(ra_q, 5'd1);
						icnt_q <= icnt_q + 4'd1;
					end
					if (rv_s1) begin
						hdr_q  <= {ram_rdata, hdr_q[95:8]};
						ccnt_q <= ccnt_q + 4'd1;
					end
				end
				fprq_pkg::S_CHK: begin
					if (h_status != fprq_pkg::ST_OK) begin
						res_status_q <= h_status;
						rp_q         <= '0;
						cp_q         <= '0;
						wwp_q        <= '0;
						write_left_q <= '0;
						write_open_q <= 1'b0;
						read_left_q  <= '0;
						read_open_q  <= 1'b0;
						open_flow_q  <= '0;
						open_len_q   <= '0;
						msg_q        <= '0;
					end else begin
						rp_q        <= wadd(rp_q, 5'd12);
						open_flow_q <= h_tag;
						open_len_q  <= 12'(h_total - 32'd16);
						read_left_q <= AW'(h_total - 32'd16);
						read_open_q <= 1'b1;
					end
				end
				// Choose a payload byte fetch or the trailer fetch.
				fprq_pkg::S_PAY: begin
					res_rd_q <= 1'b1;
					ra_q     <= rp_q;
					icnt_q   <= '0;
					ccnt_q   <= '0;
					if (read_left_q != '0) begin
						rn_q    <= 4'd1;
						phase_q <= fprq_pkg::P_BYTE;
					end else begin
						rn_q    <= 4'd4;
						phase_q <= fprq_pkg::P_TRL;
					end
				end
				fprq_pkg::S_AFTB: begin
					res_byte_q  <= hdr_q[95:88];
					rp_q        <= wadd(rp_q, 5'd1);
					read_left_q <= read_left_q - ptr_t'(1);
					ra_q        <= wadd(rp_q, 5'd1);
					rn_q        <= 4'd4;
					icnt_q      <= '0;
					ccnt_q      <= '0;
					phase_q     <= fprq_pkg::P_TRL;
				end
				fprq_pkg::S_CHKT: begin
					if (hdr_q[95:64] != fprq_pkg::FRAME_MAGIC) begin
						res_status_q <= fprq_pkg::ST_BAD_MAGIC;
						res_byte_q   <= '0;
						res_rd_q     <= 1'b0;
						rp_q         <= '0;
						cp_q         <= '0;
						wwp_q        <= '0;
						write_left_q <= '0;
						write_open_q <= 1'b0;
						read_left_q  <= '0;
						read_open_q  <= 1'b0;
						open_flow_q  <= '0;
						open_len_q   <= '0;
						msg_q        <= '0;
					end else begin
						rp_q        <= wadd(rp_q, 5'd4);
						read_open_q <= 1'b0;
						res_last_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Response register; loaded when the response slot is free.
	always_ff @(posedge clk) begin
		if (state_q == fprq_pkg::S_RESP && slot_free) begin
			rsp_q.status        <= res_status_q;
			rsp_q.read_byte     <= res_byte_q;
			rsp_q.read_flow     <= res_rd_q ? open_flow_q : 32'd0;
			rsp_q.read_len      <= res_rd_q ? open_len_q : 12'd0;
			rsp_q.last          <= res_last_q;
			rsp_q.message_count <= msg_q;
		end
	end

`ifndef SYNTHESIS
	// A response appears only out of the response state.
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == fprq_pkg::S_RESP))
		else $error("response raised outside the response state");

	// The ring port never reads and writes in the same cycle.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring read and write overlap");

	// Payload bytes remain only while a packet is open for reading.
	a_left_open: assert property (@(posedge clk) disable iff (!arst_n)
		(read_left_q != '0) |-> read_open_q)
		else $error("read bytes left with no open packet");
`endif

endmodule
`default_nettype wire

### design/fprq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int RING_SIZE = 4096;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	fprq_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	fprq_pkg::rsp_t rsp;
	logic           cfg_we;
	logic [12:0]    cfg_wdata;

	framed_packet_ring_queue_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Requests waiting to be driven and responses waiting to arrive.
	fprq_pkg::req_t pending_reqs[$];
	fprq_pkg::rsp_t expected_rsps[$];

	int fail_count = 0;
	int rsp_count = 0;
	int packets_done = 0;
	int error_rsps = 0;
	int idle_cycles = 0;
	int req_gap = 0;
	int rsp_stall = 0;
	bit req_fired = 0;
	bit calm = 0;

	// Shadow copy of the queue state.
	logic [7:0]  ring_img [RING_SIZE];
	int unsigned rd_ptr, commit_ptr, wr_ptr;
	int unsigned wr_left, rd_left, cur_flow, cur_len;
	bit          wr_open, rd_open;
	logic [31:0] msg_cnt;
	logic [12:0] read_limit;

	function automatic int unsigned ring_at(int unsigned p, int unsigned n);
		return (p + n) % RING_SIZE;
	endfunction

	function automatic void put_word(int unsigned p, logic [31:0] v);
		for (int i = 0; i < 4; i++) ring_img[ring_at(p, i)] = v[8*i +: 8];
	endfunction

	function automatic logic [31:0] get_word(int unsigned p);
		logic [31:0] v;
		for (int i = 0; i < 4; i++) v[8*i +: 8] = ring_img[ring_at(p, i)];
		return v;
	endfunction

	function automatic void drop_queue();
		rd_ptr = 0;
		commit_ptr = 0;
		wr_ptr = 0;
		wr_left = 0;
		wr_open = 0;
		rd_left = 0;
		rd_open = 0;
		cur_flow = 0;
		cur_len = 0;
		msg_cnt = '0;
	endfunction

	function automatic void seal_packet();
		put_word(wr_ptr, fprq_pkg::FRAME_MAGIC);
		commit_ptr = ring_at(wr_ptr, 4);
		wr_open = 0;
		msg_cnt++;
	endfunction

	// Work out the response that one request produces and update the shadow state.
	function automatic fprq_pkg::rsp_t queue_step(fprq_pkg::req_t r);
		fprq_pkg::rsp_t e;
		int unsigned total, free_b, used_b;
		logic [31:0] magic, tlen, tag;
		bit ok;
		e = '0;
		ok = 1;
		case (r.func)
			fprq_pkg::FN_BEGIN: begin
				total = 32'(r.payload_len) + 32'd16;
				free_b = rd_ptr > commit_ptr ? rd_ptr - commit_ptr
				                             : rd_ptr + RING_SIZE - commit_ptr;
				wr_open = 0;
				wr_left = 0;
				if (free_b <= total) begin
					e.status = fprq_pkg::ST_FULL;
				end else begin
					put_word(commit_ptr, fprq_pkg::FRAME_MAGIC);
					put_word(ring_at(commit_ptr, 4), total);
					put_word(ring_at(commit_ptr, 8), r.flow);
					wr_ptr = ring_at(commit_ptr, 12);
					wr_left = 32'(r.payload_len);
					wr_open = 1;
					if (r.payload_len == 12'd0) seal_packet();
				end
			end
			fprq_pkg::FN_WRITE: begin
				if (!wr_open) begin
					e.status = fprq_pkg::ST_NO_WRITE;
				end else begin
					ring_img[wr_ptr] = r.data_byte;
					wr_ptr = ring_at(wr_ptr, 1);
					wr_left--;
					if (wr_left == 0) seal_packet();
				end
			end
			fprq_pkg::FN_READ: begin
				if (!rd_open) begin
					if (rd_ptr == commit_ptr) begin
						e.status = fprq_pkg::ST_EMPTY;
						ok = 0;
					end else begin
						used_b = commit_ptr > rd_ptr ? commit_ptr - rd_ptr
						                             : commit_ptr + RING_SIZE - rd_ptr;
						magic = get_word(rd_ptr);
						tlen = get_word(ring_at(rd_ptr, 4));
						tag = get_word(ring_at(rd_ptr, 8));
						if (msg_cnt > 0) msg_cnt--;
						if (magic != fprq_pkg::FRAME_MAGIC) begin
							e.status = fprq_pkg::ST_BAD_MAGIC;
						end else if (tlen > used_b || tlen < 32'd16) begin
							e.status = fprq_pkg::ST_LEN_BAD;
						end else if (tlen - 32'd12 > 32'(read_limit)) begin
							e.status = fprq_pkg::ST_TOO_BIG;
						end
						if (e.status != fprq_pkg::ST_OK) begin
							drop_queue();
							ok = 0;
						end else begin
							rd_ptr = ring_at(rd_ptr, 12);
							cur_flow = tag;
							cur_len = (tlen - 32'd16) & 32'hFFF;
							rd_left = tlen - 32'd16;
							rd_open = 1;
						end
					end
				end
				if (ok) begin
					e.read_flow = cur_flow;
					e.read_len = 12'(cur_len);
					if (rd_left > 0) begin
						e.read_byte = ring_img[rd_ptr];
						rd_ptr = ring_at(rd_ptr, 1);
						rd_left--;
					end
					if (rd_left == 0) begin
						if (get_word(rd_ptr) != fprq_pkg::FRAME_MAGIC) begin
							drop_queue();
							e.status = fprq_pkg::ST_BAD_MAGIC;
							e.read_byte = '0;
							e.read_flow = '0;
							e.read_len = '0;
						end else begin
							rd_ptr = ring_at(rd_ptr, 4);
							rd_open = 0;
							e.last = 1'b1;
						end
					end
				end
			end
			default: drop_queue();
		endcase
		e.message_count = msg_cnt;
		return e;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Clock.
	initial clk = 0;
	always #6 clk = ~clk;

	// Request driver: one transaction at a time from the pending queue.
	always @(negedge clk) begin
		logic v;
		v = req_valid;
		if (arst_n) begin
			if (req_fired) begin
				v = 0;
				req_fired = 0;
			end
			if (!v) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					v = 1;
					if ($urandom_range(0, 49) == 0) calm = ~calm;
					req_gap = calm ? 0 : $urandom_range(0, 10);
				end
			end
			req_valid <= v;
			if (rsp_stall > 0) begin
				rsp_ready <= 0;
				rsp_stall--;
			end else begin
				rsp_ready <= 1;
			end
		end else begin
			req_valid <= 1'b0;
			req <= '0;
			rsp_ready <= 1'b0;
		end
	end

	// Monitor: predict on each accepted request, check each accepted response.
	always @(posedge clk) begin
		fprq_pkg::rsp_t e;
		if (arst_n) begin
			idle_cycles++;
			if (req_valid && req_ready) begin
				expected_rsps.push_back(queue_step(req));
				req_fired = 1;
				idle_cycles = 0;
			end
			if (rsp_valid && rsp_ready) begin
				idle_cycles = 0;
				rsp_stall = calm ? 0 : $urandom_range(0, 10);
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					e = expected_rsps.pop_front();
					rsp_count++;
					if (e.last) packets_done++;
					if (e.status != fprq_pkg::ST_OK) error_rsps++;
					check_field("status", 32'(e.status), 32'(rsp.status));
					check_field("read_byte", 32'(e.read_byte), 32'(rsp.read_byte));
					check_field("read_flow", e.read_flow, rsp.read_flow);
					check_field("read_len", 32'(e.read_len), 32'(rsp.read_len));
					check_field("last", 32'(e.last), 32'(rsp.last));
					check_field("message_count", e.message_count, rsp.message_count);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	function automatic fprq_pkg::req_t make_req(logic [1:0] f, logic [7:0] d, logic [11:0] len,
	                                            logic [31:0] fl);
		fprq_pkg::req_t r;
		r.func = f;
		r.data_byte = d;
		r.payload_len = len;
		r.flow = fl;
		return r;
	endfunction

	// A whole packet: begin write followed by its payload bytes.
	task automatic add_packet(int unsigned len);
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'($urandom), 12'(len), $urandom));
		for (int i = 0; i < len; i++)
			pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'($urandom),
			                                12'($urandom), $urandom));
	endtask

	task automatic add_random(int count);
		int n;
		int pick;
		int len;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len = ($urandom_range(0, 59) == 0) ? $urandom_range(1000, 3000)
				                                   : $urandom_range(0, 24);
				// Keep the batch close to its requested size.
				if (len + 1 > count - n) len = count - n - 1;
				add_packet(len);
				n += len + 1;
			end else if (pick < 85) begin
				len = $urandom_range(1, 30);
				for (int i = 0; i < len; i++)
					pending_reqs.push_back(make_req(fprq_pkg::FN_READ, 8'($urandom),
					                                12'($urandom), $urandom));
				n += len;
			end else if (pick < 90) begin
				pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'($urandom),
				                                12'($urandom), $urandom));
				n++;
			end else if (pick < 93) begin
				pending_reqs.push_back(make_req(fprq_pkg::FN_CLEAR, 8'($urandom),
				                                12'($urandom), $urandom));
				n++;
			end else begin
				// Abandoned packet: a begin and half of its bytes, left open.
				len = $urandom_range(2, 20);
				pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'($urandom),
				                                12'(len), $urandom));
				for (int i = 0; i < len / 2; i++)
					pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'($urandom),
					                                12'($urandom), $urandom));
				n += len / 2 + 1;
			end
		end
	endtask

	// Wait until every transaction has gone through, then let the unit settle.
	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_limit(logic [12:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		read_limit = v;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		foreach (ring_img[i]) ring_img[i] = '0;
		drop_queue();
		read_limit = 13'd4096;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed opening: empty payload, empty queue, stray write, full ring,
		// extreme bytes, a dropped packet and a clear.
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd0, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(fprq_pkg::FN_READ, 8'hFF, 12'hFFF, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_READ, 8'h00, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'hFF, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd4080, 32'h1234_5678));
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd3, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'h00, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'hFF, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'h5A, 12'd0, 32'h0));
		repeat (3) pending_reqs.push_back(make_req(fprq_pkg::FN_READ, 8'h00, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd2, 32'hA5A5_A5A5));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'h11, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd1, 32'h5A5A_5A5A));
		pending_reqs.push_back(make_req(fprq_pkg::FN_WRITE, 8'hAA, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_BEGIN, 8'h00, 12'd1, 32'h0F0F_0F0F));
		pending_reqs.push_back(make_req(fprq_pkg::FN_CLEAR, 8'h00, 12'd0, 32'h0));
		pending_reqs.push_back(make_req(fprq_pkg::FN_READ, 8'h00, 12'd0, 32'h0));
		add_random(850);
		wait_idle();

		// Smallest limit: every packet read fails as too big.
		set_limit(13'd0);
		add_random(150);
		wait_idle();

		// Largest limit.
		set_limit(13'h1FFF);
		add_random(300);
		wait_idle();

		// A tight limit that splits packets into accepted and rejected ones.
		set_limit(13'($urandom_range(16, 40)));
		add_random(550);
		wait_idle();

		$display("Checked %0d responses: %0d packets read whole, %0d error statuses,",
		         rsp_count, packets_done, error_rsps);
		$display("over four read-limit settings including both extremes.");
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

### framed_packet_ring_queue_unit.f
design/fprq_pkg.sv
design/fprq_ram.sv
design/framed_packet_ring_queue_unit.sv
tb/sv/testbench.sv
